// ===== src/acpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_pkg
// Shared types and constants of the accumulator machine: word widths,
// item commands, instruction opcodes, status codes and the control groups
// passed between the sequencer, the memory block and the execute unit.
// ----------------------------------------------------------------------------
package acpu_pkg;

  // Fixed widths of the machine.
  localparam int unsigned DATA_W       = 16;
  localparam int unsigned ADDR_W       = 12;
  localparam int unsigned PC_W         = 13;
  localparam int unsigned MEM_WORDS_DEF = 4096;

  // Command carried with each input word.
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_BREAK = 2'd2
  } cmd_e;

  // Instruction opcodes, taken from the top nibble.
  typedef enum logic [3:0] {
    OPC_HALT  = 4'h0,
    OPC_IO    = 4'h1,
    OPC_SHIFT = 4'h2,
    OPC_LOAD  = 4'h3,
    OPC_STORE = 4'h4,
    OPC_ADD   = 4'h5,
    OPC_SUB   = 4'h6,
    OPC_AND   = 4'h7,
    OPC_OR    = 4'h8,
    OPC_XOR   = 4'h9,
    OPC_NOT   = 4'hA,
    OPC_NOP   = 4'hB,
    OPC_JMP   = 4'hC,
    OPC_JZ    = 4'hD,
    OPC_JN    = 4'hE,
    OPC_BAL   = 4'hF
  } opc_e;

  // Status reported with each result word.
  typedef enum logic [1:0] {
    STAT_HALT  = 2'd0,
    STAT_EXEC  = 2'd1,
    STAT_BREAK = 2'd2,
    STAT_ERROR = 2'd3
  } stat_e;

  // Request to the word memory.
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  // Request to the breakpoint flag memory.
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic              wdata;
  } brk_req_t;

  // Outcome of one executed instruction.
  typedef struct packed {
    stat_e             status;
    logic [DATA_W-1:0] acc_nxt;
    logic [DATA_W-1:0] out_value;
    logic              pc_take;
    logic              out_valid;
    logic              out_char;
    logic              in_taken;
  } alu_res_t;

endpackage

// ===== src/acpu_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_mem
// Single-port word memory and single-port breakpoint flag memory, both
// with registered read data. Read data holds until the next read.
// ----------------------------------------------------------------------------
module acpu_mem #(
  parameter int unsigned MEM_WORDS = acpu_pkg::MEM_WORDS_DEF
) (
  input  logic                      clk_i,
  input  acpu_pkg::mem_req_t        mem_req_i,
  output logic [acpu_pkg::DATA_W-1:0] mem_rdata_o,
  input  acpu_pkg::brk_req_t        brk_req_i,
  output logic                      brk_rdata_o
);
  import acpu_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [DATA_W-1:0] mem_q [MEM_WORDS];
  logic              brk_q [MEM_WORDS];
  logic [DATA_W-1:0] mem_rdata_q;
  logic              brk_rdata_q;

  // Word memory port.
  always_ff @(posedge clk_i) begin
    if (mem_req_i.en) begin
      if (mem_req_i.we) begin
        mem_q[mem_req_i.addr[AW-1:0]] <= mem_req_i.wdata;
      end else begin
        mem_rdata_q <= mem_q[mem_req_i.addr[AW-1:0]];
      end
    end
  end

  // Breakpoint flag port.
  always_ff @(posedge clk_i) begin
    if (brk_req_i.en) begin
      if (brk_req_i.we) begin
        brk_q[brk_req_i.addr[AW-1:0]] <= brk_req_i.wdata;
      end else begin
        brk_rdata_q <= brk_q[brk_req_i.addr[AW-1:0]];
      end
    end
  end

  assign mem_rdata_o = mem_rdata_q;
  assign brk_rdata_o = brk_rdata_q;

endmodule

// ===== src/acpu_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_alu
// Execute unit: from the fetched instruction, the accumulator and the
// operand word it forms the new accumulator, the status and the I/O flags.
// ----------------------------------------------------------------------------
module acpu_alu (
  input  logic [acpu_pkg::DATA_W-1:0] ins_i,
  input  logic [acpu_pkg::DATA_W-1:0] acc_i,
  input  logic [acpu_pkg::DATA_W-1:0] opnd_i,
  input  logic [acpu_pkg::DATA_W-1:0] data_i,
  input  logic [acpu_pkg::PC_W-1:0]   pc_i,
  input  logic                        pc_ok_i,
  input  logic                        brk_hit_i,
  output acpu_pkg::alu_res_t          res_o
);
  import acpu_pkg::*;

  opc_e              opc;
  logic [3:0]        sh_n;
  logic [2*DATA_W-1:0] dbl;
  logic [2*DATA_W-1:0] rot_l;
  logic [2*DATA_W-1:0] rot_r;
  logic [DATA_W-1:0] sh_res;
  logic              sub_bad;
  alu_res_t          res;

  assign opc     = opc_e'(ins_i[15:12]);
  assign sh_n    = ins_i[3:0];
  assign sub_bad = ins_i[9] | ins_i[8];

  // Shift and rotate by the low nibble; bit 11 selects rotate, bit 10 right.
  assign dbl   = {acc_i, acc_i};
  assign rot_l = dbl << sh_n;
  assign rot_r = dbl >> sh_n;
  always_comb begin
    case ({ins_i[11], ins_i[10]})
      2'b00:   sh_res = acc_i << sh_n;
      2'b01:   sh_res = acc_i >> sh_n;
      2'b10:   sh_res = rot_l[2*DATA_W-1:DATA_W];
      default: sh_res = rot_r[DATA_W-1:0];
    endcase
  end

  // Instruction decode and result forming.
  always_comb begin
    res           = '0;
    res.status    = STAT_EXEC;
    res.acc_nxt   = acc_i;
    res.pc_take   = 1'b1;
    if (!pc_ok_i) begin
      res.status  = STAT_ERROR;
      res.pc_take = 1'b0;
    end else begin
      case (opc)
        OPC_HALT: begin
          res.status  = STAT_HALT;
          res.pc_take = 1'b0;
        end
        OPC_IO: begin
          if (sub_bad) begin
            res.status  = STAT_ERROR;
            res.pc_take = 1'b0;
          end else if (ins_i[11]) begin
            res.out_valid = 1'b1;
            res.out_char  = ins_i[10];
            res.out_value = acc_i;
          end else begin
            res.in_taken = 1'b1;
            res.acc_nxt  = data_i;
          end
        end
        OPC_SHIFT: begin
          // The accumulator changes even when the sub-opcode is invalid.
          res.acc_nxt = sh_res;
          if (sub_bad) begin
            res.status  = STAT_ERROR;
            res.pc_take = 1'b0;
          end
        end
        OPC_LOAD:  res.acc_nxt = opnd_i;
        OPC_ADD:   res.acc_nxt = acc_i + opnd_i;
        OPC_SUB:   res.acc_nxt = acc_i - opnd_i;
        OPC_AND:   res.acc_nxt = acc_i & opnd_i;
        OPC_OR:    res.acc_nxt = acc_i | opnd_i;
        OPC_XOR:   res.acc_nxt = acc_i ^ opnd_i;
        OPC_NOT:   res.acc_nxt = ~acc_i;
        OPC_BAL:   res.acc_nxt = DATA_W'(pc_i + PC_W'(1));
        default:   ;
      endcase
    end
    if (res.pc_take && brk_hit_i) begin
      res.status = STAT_BREAK;
    end
  end

  assign res_o = res;

endmodule

// ===== src/accumulator_cpu_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_step
// Flow: a memory write or breakpoint word gives its result via ST_WDONE, an
// execute word via fetch, then operand access (ST_FETCH, ST_OPER). One write
// or breakpoint word is taken per cycle unless the result side stalls; none
// in ST_FETCH. The single word memory port carries fetch and operand access.
// Reset: pc and accumulator clear at once, then a pass over all MEM_WORDS
// words zeroes memory and breakpoint flags while s_axis_tready stays low.
// ----------------------------------------------------------------------------
module accumulator_cpu_step #(
  parameter int unsigned MEM_WORDS = acpu_pkg::MEM_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // addr[11:0], data[27:12], zero fill
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  // Result words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // status[1:0], pc_now[14:2], acc_now[30:15],
                                     // out_valid[31], out_value[47:32],
                                     // input_taken[48], zero fill
  output logic [0:0]  m_axis_tuser   // out_is_char[0]
);
  import acpu_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam logic [PC_W-1:0] MemWordsW = PC_W'(MEM_WORDS);
  localparam logic [AW-1:0]   ClrLast   = AW'(MEM_WORDS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_OPER,
    ST_WDONE
  } state_e;

  typedef struct packed {
    stat_e             status;
    logic [PC_W-1:0]   pc_now;
    logic [DATA_W-1:0] acc_now;
    logic              out_valid;
    logic [DATA_W-1:0] out_value;
    logic              out_is_char;
    logic              input_taken;
  } res_t;

  state_e            state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [DATA_W-1:0] ins_q, ins_d;
  logic [PC_W-1:0]   next_q, next_d;
  logic              pc_ok_q, pc_ok_d;
  logic              a_ok_q, a_ok_d;
  logic              brk_ok_q, brk_ok_d;
  stat_e             wstat_q, wstat_d;
  logic              mv_q, mv_d;
  res_t              res_q, res_d;

  mem_req_t          mem_req;
  brk_req_t          brk_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              brk_rdata;
  alu_res_t          alu_res;
  logic [DATA_W-1:0] opnd;

  logic              out_free;
  logic              accept;
  cmd_e              in_cmd;
  logic [ADDR_W-1:0] in_addr;
  logic [DATA_W-1:0] in_data;
  logic              in_addr_ok;

  // Fetch-stage decode signals.
  opc_e              f_opc;
  logic [ADDR_W-1:0] f_a;
  logic              f_a_ok;
  logic [PC_W-1:0]   f_inc;
  logic [PC_W-1:0]   f_next;
  logic [PC_W-1:0]   f_prev;

  assign in_cmd     = cmd_e'(s_axis_tuser);
  assign in_addr    = s_axis_tdata[ADDR_W-1:0];
  assign in_data    = s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W];
  assign in_addr_ok = {1'b0, in_addr} < MemWordsW;

  assign out_free = !mv_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) ||
                         ((state_q == ST_OPER || state_q == ST_WDONE) && out_free);
  assign accept = s_axis_tvalid && s_axis_tready;

  // Memories.
  acpu_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk_i       (clk_i),
    .mem_req_i   (mem_req),
    .mem_rdata_o (mem_rdata),
    .brk_req_i   (brk_req),
    .brk_rdata_o (brk_rdata)
  );

  // Execute unit; an operand address beyond memory reads as zero.
  assign opnd = a_ok_q ? mem_rdata : '0;

  acpu_alu u_alu (
    .ins_i     (ins_q),
    .acc_i     (acc_q),
    .opnd_i    (opnd),
    .data_i    (data_q),
    .pc_i      (pc_q),
    .pc_ok_i   (pc_ok_q),
    .brk_hit_i (brk_ok_q && brk_rdata),
    .res_o     (alu_res)
  );

  // Decode of the fetched word: branch target and operand address check.
  assign f_opc  = opc_e'(mem_rdata[15:12]);
  assign f_a    = mem_rdata[ADDR_W-1:0];
  assign f_a_ok = {1'b0, f_a} < MemWordsW;
  assign f_inc  = pc_q + PC_W'(1);
  always_comb begin
    case (f_opc)
      OPC_JMP, OPC_BAL: f_next = {1'b0, f_a};
      OPC_JZ:           f_next = (acc_q == '0) ? {1'b0, f_a} : f_inc;
      OPC_JN:           f_next = acc_q[DATA_W-1] ? {1'b0, f_a} : f_inc;
      default:          f_next = f_inc;
    endcase
  end
  assign f_prev = f_next - PC_W'(1);

  // Sequencer: clearing pass, fetch, operand access and result forming.
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    pc_d     = pc_q;
    acc_d    = acc_q;
    data_d   = data_q;
    ins_d    = ins_q;
    next_d   = next_q;
    pc_ok_d  = pc_ok_q;
    a_ok_d   = a_ok_q;
    brk_ok_d = brk_ok_q;
    wstat_d  = wstat_q;
    res_d    = res_q;
    mv_d     = mv_q && !m_axis_tready;
    mem_req  = '0;
    brk_req  = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_req.en   = 1'b1;
        mem_req.we   = 1'b1;
        mem_req.addr = ADDR_W'(clr_q);
        brk_req.en   = 1'b1;
        brk_req.we   = 1'b1;
        brk_req.addr = ADDR_W'(clr_q);
        clr_d        = clr_q + AW'(1);
        if (clr_q == ClrLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_FETCH: begin
        ins_d    = mem_rdata;
        next_d   = f_next;
        a_ok_d   = f_a_ok;
        brk_ok_d = (f_next != '0) && (f_prev < MemWordsW);
        // Operand read or store through the word port.
        case (f_opc)
          OPC_LOAD, OPC_ADD, OPC_SUB, OPC_AND, OPC_OR, OPC_XOR: begin
            mem_req.en   = f_a_ok;
            mem_req.addr = f_a;
          end
          OPC_STORE: begin
            mem_req.en    = f_a_ok && pc_ok_q;
            mem_req.we    = 1'b1;
            mem_req.addr  = f_a;
            mem_req.wdata = acc_q;
          end
          default: ;
        endcase
        // Flag of the word just before the new pc.
        brk_req.en   = (f_next != '0) && (f_prev < MemWordsW);
        brk_req.addr = f_prev[ADDR_W-1:0];
        state_d      = ST_OPER;
      end
      ST_OPER: begin
        if (out_free) begin
          pc_d              = alu_res.pc_take ? next_q : pc_q;
          acc_d             = alu_res.acc_nxt;
          res_d.status      = alu_res.status;
          res_d.pc_now      = alu_res.pc_take ? next_q : pc_q;
          res_d.acc_now     = alu_res.acc_nxt;
          res_d.out_valid   = alu_res.out_valid;
          res_d.out_value   = alu_res.out_value;
          res_d.out_is_char = alu_res.out_char;
          res_d.input_taken = alu_res.in_taken;
          mv_d              = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_WDONE: begin
        if (out_free) begin
          res_d.status      = wstat_q;
          res_d.pc_now      = pc_q;
          res_d.acc_now     = acc_q;
          res_d.out_valid   = 1'b0;
          res_d.out_value   = '0;
          res_d.out_is_char = 1'b0;
          res_d.input_taken = 1'b0;
          mv_d              = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: ;
    endcase

    // New word; the fetch address uses the pc as updated in this cycle.
    if (accept) begin
      case (in_cmd)
        CMD_WRITE: begin
          mem_req.en    = in_addr_ok;
          mem_req.we    = 1'b1;
          mem_req.addr  = in_addr;
          mem_req.wdata = in_data;
          wstat_d       = in_addr_ok ? STAT_EXEC : STAT_ERROR;
          state_d       = ST_WDONE;
        end
        CMD_BREAK: begin
          brk_req.en    = in_addr_ok;
          brk_req.we    = 1'b1;
          brk_req.addr  = in_addr;
          brk_req.wdata = 1'b1;
          wstat_d       = in_addr_ok ? STAT_EXEC : STAT_ERROR;
          state_d       = ST_WDONE;
        end
        CMD_EXEC: begin
          data_d       = in_data;
          pc_ok_d      = pc_d < MemWordsW;
          mem_req.en   = pc_d < MemWordsW;
          mem_req.addr = pc_d[ADDR_W-1:0];
          state_d      = ST_FETCH;
        end
        default: begin
          wstat_d = STAT_ERROR;
          state_d = ST_WDONE;
        end
      endcase
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      pc_q     <= '0;
      acc_q    <= '0;
      data_q   <= '0;
      ins_q    <= '0;
      next_q   <= '0;
      pc_ok_q  <= 1'b0;
      a_ok_q   <= 1'b0;
      brk_ok_q <= 1'b0;
      wstat_q  <= STAT_EXEC;
      mv_q     <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      pc_q     <= pc_d;
      acc_q    <= acc_d;
      data_q   <= data_d;
      ins_q    <= ins_d;
      next_q   <= next_d;
      pc_ok_q  <= pc_ok_d;
      a_ok_q   <= a_ok_d;
      brk_ok_q <= brk_ok_d;
      wstat_q  <= wstat_d;
      mv_q     <= mv_d;
      res_q    <= res_d;
    end
  end

  // Result word packing.
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {7'b0, res_q.input_taken, res_q.out_value, res_q.out_valid,
                          res_q.acc_now, res_q.pc_now, res_q.status};
  assign m_axis_tuser  = res_q.out_is_char;

endmodule

// ===== tb/accumulator_cpu_step_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_step_test
// Self-checking bench for the accumulator machine step block. A behavioral
// copy of the machine (memory image, breakpoint flags, pc and accumulator)
// computes the result of every accepted input word; a checker compares each
// result word field by field, in order. Directed cases come first, then
// random programs loaded and run under three idling mixes; pc overflow last.
// ----------------------------------------------------------------------------
module accumulator_cpu_step_test;
  import acpu_pkg::*;

  localparam int unsigned MEM_WORDS      = MEM_WORDS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  // Sub-operation codes in bits 11..10 of I/O and shift instructions.
  localparam logic [1:0] IO_IN_HEX   = 2'b00;
  localparam logic [1:0] IO_IN_CHAR  = 2'b01;
  localparam logic [1:0] IO_OUT_HEX  = 2'b10;
  localparam logic [1:0] IO_OUT_CHAR = 2'b11;
  localparam logic [1:0] SH_LEFT     = 2'b00;
  localparam logic [1:0] SH_RIGHT    = 2'b01;
  localparam logic [1:0] ROT_LEFT    = 2'b10;
  localparam logic [1:0] ROT_RIGHT   = 2'b11;

  typedef struct packed {
    stat_e       status;
    logic [12:0] pc_now;
    logic [15:0] acc_now;
    logic        out_valid;
    logic [15:0] out_value;
    logic        out_is_char;
    logic        input_taken;
  } step_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // addr[11:0], data[27:12], zero fill
  logic [1:0]  s_axis_tuser = '0;  // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;       // status[1:0], pc_now[14:2], acc_now[30:15],
                                   // out_valid[31], out_value[47:32],
                                   // input_taken[48], zero fill
  logic [0:0]  m_axis_tuser;       // out_is_char[0]

  // Machine image kept by the bench.
  logic [15:0]  mem_img [MEM_WORDS] = '{default: '0};
  bit           brk_img [MEM_WORDS] = '{default: 1'b0};
  logic [12:0]  pc_q  = '0;
  logic [15:0]  acc_q = '0;

  step_result_t step_results_q [$];
  step_result_t head_step;
  int unsigned  fail_count  = 0;
  int unsigned  words_sent  = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  src_idle_pct = 36;
  int unsigned  snk_idle_pct = 83;

  accumulator_cpu_step DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Apply one input word to the machine image and return its result.
  function automatic step_result_t run_machine_step(cmd_e cmd, logic [11:0] addr,
                                                    logic [15:0] data);
    step_result_t r;
    logic [15:0]  ins;
    logic [15:0]  mval;
    logic [11:0]  opnd;
    logic [12:0]  nxt;
    logic [31:0]  dbl;
    logic         moved;
    r.status      = STAT_ERROR;
    r.out_valid   = 1'b0;
    r.out_value   = '0;
    r.out_is_char = 1'b0;
    r.input_taken = 1'b0;
    case (cmd)
      CMD_WRITE: begin
        mem_img[addr] = data;
        r.status = STAT_EXEC;
      end
      CMD_BREAK: begin
        brk_img[addr] = 1'b1;
        r.status = STAT_EXEC;
      end
      CMD_EXEC: begin
        // A pc past the end of memory is stuck with an error.
        if (pc_q < MEM_WORDS) begin
          ins      = mem_img[pc_q[11:0]];
          opnd     = ins[11:0];
          mval     = mem_img[opnd];
          nxt      = pc_q + 13'd1;
          moved    = 1'b1;
          r.status = STAT_EXEC;
          case (opc_e'(ins[15:12]))
            OPC_HALT: begin
              r.status = STAT_HALT;
              moved = 1'b0;
            end
            OPC_IO: begin
              if (ins[9] || ins[8]) begin
                r.status = STAT_ERROR;
                moved = 1'b0;
              end else if (ins[11:10] == IO_OUT_HEX || ins[11:10] == IO_OUT_CHAR) begin
                r.out_valid   = 1'b1;
                r.out_value   = acc_q;
                r.out_is_char = (ins[11:10] == IO_OUT_CHAR);
              end else begin
                r.input_taken = 1'b1;
                acc_q = data;
              end
            end
            OPC_SHIFT: begin
              // The accumulator moves even when the sub-operation is bad.
              dbl = {acc_q, acc_q};
              case (ins[11:10])
                SH_LEFT:  acc_q = acc_q << ins[3:0];
                SH_RIGHT: acc_q = acc_q >> ins[3:0];
                ROT_LEFT: begin
                  dbl = dbl << ins[3:0];
                  acc_q = dbl[31:16];
                end
                ROT_RIGHT: begin
                  dbl = dbl >> ins[3:0];
                  acc_q = dbl[15:0];
                end
                default: ;
              endcase
              if (ins[9] || ins[8]) begin
                r.status = STAT_ERROR;
                moved = 1'b0;
              end
            end
            OPC_LOAD:  acc_q = mval;
            OPC_STORE: mem_img[opnd] = acc_q;
            OPC_ADD:   acc_q = acc_q + mval;
            OPC_SUB:   acc_q = acc_q - mval;
            OPC_AND:   acc_q = acc_q & mval;
            OPC_OR:    acc_q = acc_q | mval;
            OPC_XOR:   acc_q = acc_q ^ mval;
            OPC_NOT:   acc_q = ~acc_q;
            OPC_NOP:   ;
            OPC_JMP:   nxt = {1'b0, opnd};
            OPC_JZ:    if (acc_q == 16'd0) nxt = {1'b0, opnd};
            OPC_JN:    if (acc_q[15]) nxt = {1'b0, opnd};
            OPC_BAL: begin
              acc_q = 16'(pc_q) + 16'd1;
              nxt = {1'b0, opnd};
            end
            default: ;
          endcase
          // A breakpoint on the word just before the new pc is reported; pc 0 never breaks.
          if (moved) begin
            pc_q = nxt;
            if (nxt != 13'd0 && brk_img[12'(nxt - 13'd1)]) r.status = STAT_BREAK;
          end
        end
      end
      default: ;
    endcase
    r.pc_now  = pc_q;
    r.acc_now = acc_q;
    return r;
  endfunction

  // Send one input word and record the result it must produce.
  task automatic send_command(input cmd_e cmd, input int unsigned addr,
                              input int unsigned data);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0000, data[15:0], addr[11:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    step_results_q.push_back(run_machine_step(cmd, addr[11:0], data[15:0]));
    words_sent++;
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Result side: random back-pressure and in-order comparison.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    if (m_axis_tvalid && m_axis_tready) begin
      if (step_results_q.size() == 0) begin
        $error("result word with no step pending");
        fail_count++;
      end else begin
        head_step = step_results_q.pop_front();
        check_field("status", head_step.status, m_axis_tdata[1:0]);
        check_field("pc_now", head_step.pc_now, m_axis_tdata[14:2]);
        check_field("acc_now", head_step.acc_now, m_axis_tdata[30:15]);
        check_field("out_valid", head_step.out_valid, m_axis_tdata[31]);
        check_field("out_value", head_step.out_value, m_axis_tdata[47:32]);
        check_field("input_taken", head_step.input_taken, m_axis_tdata[48]);
        check_field("out_is_char", head_step.out_is_char, m_axis_tuser[0]);
      end
    end
  end

  // Watchdog on cycles where neither side moves a word.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("accumulator_cpu_step regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Cleared memory holds halt everywhere.
  task automatic test_reset_state();
    send_command(CMD_EXEC, 0, $urandom_range(16'hFFFF));
  endtask

  // Input, both outputs, a rotate left by 15, and bad sub-operations.
  task automatic test_io_and_shift();
    send_command(CMD_WRITE, 0, {OPC_IO, IO_IN_HEX, 10'h000});
    send_command(CMD_WRITE, 1, {OPC_IO, IO_OUT_CHAR, 10'h000});
    send_command(CMD_WRITE, 2, {OPC_IO, IO_OUT_HEX, 10'h000});
    send_command(CMD_WRITE, 3, {OPC_SHIFT, ROT_LEFT, 10'h00F});
    send_command(CMD_WRITE, 4, {OPC_SHIFT, SH_RIGHT, 2'b01, 8'h00});
    send_command(CMD_EXEC, 0, 16'h8001);
    send_command(CMD_EXEC, 0, 16'h0000);
    send_command(CMD_EXEC, 0, 16'h0000);
    send_command(CMD_EXEC, 0, 16'h0000);
    send_command(CMD_EXEC, 0, 16'h0000);
    send_command(CMD_WRITE, 4, {OPC_IO, IO_IN_CHAR, 2'b01, 8'h00});
    send_command(CMD_EXEC, 0, 16'hFFFF);
  endtask

  // Branch-and-link back to word 0, then a breakpoint hit on the way out.
  task automatic test_branch_and_breakpoints();
    send_command(CMD_WRITE, 4, {OPC_BAL, 12'h000});
    send_command(CMD_WRITE, MEM_WORDS - 1, 16'h0000);
    send_command(CMD_BREAK, MEM_WORDS - 1, 16'hFFFF);
    send_command(CMD_BREAK, 0, 16'h0000);
    send_command(CMD_EXEC, 0, 16'h1234);
    send_command(CMD_EXEC, 0, 16'hFFFF);
  endtask

  // Load short random programs at the pc and run them, with some noise.
  task automatic test_random_programs(input int unsigned n_words);
    int unsigned start;
    int unsigned base;
    int unsigned len;
    int unsigned steps;
    int unsigned opc;
    int unsigned low;
    int unsigned d;
    int unsigned i;
    start = words_sent;
    while (words_sent - start < n_words) begin
      base = pc_q;
      len  = $urandom_range(8, 2);
      for (i = 0; i < len && base + i < MEM_WORDS; i++) begin
        opc = $urandom_range(15);
        low = $urandom_range(4095);
        if ((opc == OPC_IO || opc == OPC_SHIFT) && $urandom_range(4) != 0) begin
          low[9:8] = 2'b00;
        end else if (opc >= OPC_LOAD && opc <= OPC_XOR && $urandom_range(1) == 1) begin
          low = $urandom_range(63);
        end else if (opc >= OPC_JMP && $urandom_range(1) == 1) begin
          low = base + $urandom_range(len);
          if (low >= MEM_WORDS) low = MEM_WORDS - 1;
        end
        send_command(CMD_WRITE, base + i, {opc[3:0], low[11:0]});
      end
      if ($urandom_range(7) == 0 && base + len < MEM_WORDS) begin
        send_command(CMD_BREAK, base + $urandom_range(len, 1), $urandom_range(16'hFFFF));
      end
      // Stray traffic: a random word anywhere, now and then a random flag.
      if ($urandom_range(5) == 0) begin
        if ($urandom_range(3) == 0) begin
          send_command(CMD_BREAK, $urandom_range(4095), $urandom_range(16'hFFFF));
        end else begin
          send_command(CMD_WRITE, $urandom_range(4095), $urandom_range(16'hFFFF));
        end
      end
      steps = $urandom_range(len + 3, 1);
      repeat (steps) begin
        // Keep the pc from running off the end of memory.
        if (pc_q == MEM_WORDS - 1) begin
          send_command(CMD_WRITE, MEM_WORDS - 1, {OPC_JMP, 12'($urandom_range(4095))});
        end
        case ($urandom_range(7))
          0, 1:    d = 0;
          2:       d = 16'h8000 | $urandom_range(16'h7FFF);
          default: d = $urandom_range(16'hFFFF);
        endcase
        send_command(CMD_EXEC, $urandom_range(4095), d);
      end
    end
  endtask

  // Step off the last word: breakpoint there, then the pc is out of memory.
  task automatic test_pc_overflow();
    send_command(CMD_WRITE, MEM_WORDS - 1, {OPC_NOP, 12'h000});
    if (pc_q != MEM_WORDS - 1) begin
      send_command(CMD_WRITE, pc_q, {OPC_JMP, 12'hFFF});
      send_command(CMD_EXEC, 0, 16'h0000);
    end
    send_command(CMD_EXEC, 0, 16'h0000);
    send_command(CMD_EXEC, 0, 16'hFFFF);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_io_and_shift();
    test_branch_and_breakpoints();
    test_random_programs(200);
    src_idle_pct = 83;
    snk_idle_pct = 36;
    test_random_programs(200);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_programs(200);
    test_pc_overflow();
    s_axis_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (step_results_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("accumulator_cpu_step regression: pass");
    end else begin
      $display("accumulator_cpu_step regression: fail");
    end
    $finish;
  end

endmodule
